/* hdl/s5hp_pkg.sv */
package s5hp_pkg;

  localparam logic [1:0] OP_CLIENT   = 2'd0;
  localparam logic [1:0] OP_RESOLVED = 2'd1;
  localparam logic [1:0] OP_OUTCOME  = 2'd2;
  localparam logic [1:0] OP_RESTART  = 2'd3;

  localparam logic [1:0] KIND_REPLY = 2'd0;
  localparam logic [1:0] KIND_DEST  = 2'd1;
  localparam logic [1:0] KIND_RELAY = 2'd2;

  localparam logic [1:0] AK_IPV4   = 2'd0;
  localparam logic [1:0] AK_DOMAIN = 2'd1;
  localparam logic [1:0] AK_IPV6   = 2'd2;

  localparam logic [7:0] SOCKS_VER   = 8'h05;
  localparam logic [7:0] BYTE_ZERO   = 8'h00;
  localparam logic [7:0] NO_METHOD   = 8'hFF;
  localparam logic [7:0] CMD_CONNECT = 8'h01;
  localparam logic [7:0] ATYP_IPV4   = 8'h01;
  localparam logic [7:0] ATYP_DOMAIN = 8'h03;
  localparam logic [7:0] ATYP_IPV6   = 8'h04;
  localparam logic [7:0] REP_FAIL    = 8'h01;

  typedef enum logic [1:0] {
    JOB_NONE   = 2'd0,
    JOB_FAIL   = 2'd1,
    JOB_METHOD = 2'd2,
    JOB_OK     = 2'd3
  } job_e;

  // work for the back end: either a single byte or a reply burst
  typedef struct packed {
    logic       single;
    job_e       job;
    logic [1:0] kind;
    logic [7:0] data;
    logic [1:0] dest_type;
    logic       last;
    logic       bad;
    logic       v6;
    logic [15:0] port;
  } cmd_t;

  typedef struct packed {
    logic       we;
    logic [3:0] addr;
    logic [7:0] data;
  } wr_t;

endpackage

/* hdl/s5hp_front.sv */
module s5hp_front
  import s5hp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [1:0] operation_i,
  input  logic [7:0] data_byte_i,
  input  logic       connect_ok_i,
  input  logic       resolved_is_ipv6_i,
  output logic       push_o,
  output cmd_t       cmd_o,
  input  logic       full_i,
  input  logic       ok_done_i,
  output wr_t        wr_o
);

  localparam logic [3:0] PH_GREET_VER = 4'd0;
  localparam logic [3:0] PH_GREET_NUM = 4'd1;
  localparam logic [3:0] PH_METHODS   = 4'd2;
  localparam logic [3:0] PH_REQ_VER   = 4'd3;
  localparam logic [3:0] PH_REQ_CMD   = 4'd4;
  localparam logic [3:0] PH_REQ_RSV   = 4'd5;
  localparam logic [3:0] PH_REQ_ATYP  = 4'd6;
  localparam logic [3:0] PH_NAME_LEN  = 4'd7;
  localparam logic [3:0] PH_ADDR      = 4'd8;
  localparam logic [3:0] PH_WAIT      = 4'd9;
  localparam logic [3:0] PH_RELAY     = 4'd10;
  localparam logic [3:0] PH_FAILED    = 4'd11;

  logic [3:0]  phase_q, phase_d;
  logic [8:0]  cnt_q, cnt_d;
  logic [7:0]  mtot_q, mtot_d;
  logic        noauth_q, noauth_d;
  logic [1:0]  ak_q, ak_d;
  logic [7:0]  nlen_q, nlen_d;
  logic [15:0] port_q, port_d;
  logic        okpend_q, okpend_d;
  logic        fire;
  logic [8:0]  cnt_inc, alen, total;

  // hold input while a success reply still reads the address store
  assign ready_o = !full_i && !okpend_q;
  assign fire    = valid_i && ready_o;
  assign cnt_inc = cnt_q + 9'd1;
  assign alen    = (ak_q == AK_IPV4) ? 9'd4 : ((ak_q == AK_IPV6) ? 9'd16 : {1'b0, nlen_q});
  assign total   = alen + 9'd2;

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    mtot_d   = mtot_q;
    noauth_d = noauth_q;
    ak_d     = ak_q;
    nlen_d   = nlen_q;
    port_d   = port_q;
    okpend_d = okpend_q && !ok_done_i;
    push_o   = 1'b0;
    cmd_o    = '0;
    cmd_o.job = JOB_NONE;
    wr_o     = '0;
    if (fire) begin
      case (operation_i)
        OP_CLIENT: begin
          case (phase_q)
            PH_GREET_VER: begin
              if (data_byte_i != SOCKS_VER) begin
                push_o = 1'b1; cmd_o.job = JOB_FAIL; phase_d = PH_FAILED;
              end else phase_d = PH_GREET_NUM;
            end
            PH_GREET_NUM: begin
              mtot_d   = data_byte_i;
              cnt_d    = '0;
              noauth_d = 1'b0;
              if (data_byte_i == BYTE_ZERO) begin
                push_o = 1'b1; cmd_o.job = JOB_METHOD; cmd_o.bad = 1'b1;
                phase_d = PH_FAILED;
              end else phase_d = PH_METHODS;
            end
            PH_METHODS: begin
              noauth_d = noauth_q || (data_byte_i == BYTE_ZERO);
              cnt_d    = cnt_inc;
              if (cnt_inc >= {1'b0, mtot_q}) begin
                push_o = 1'b1; cmd_o.job = JOB_METHOD; cmd_o.bad = !noauth_d;
                phase_d = noauth_d ? PH_REQ_VER : PH_FAILED;
              end
            end
            PH_REQ_VER: begin
              if (data_byte_i != SOCKS_VER) begin
                push_o = 1'b1; cmd_o.job = JOB_FAIL; phase_d = PH_FAILED;
              end else phase_d = PH_REQ_CMD;
            end
            PH_REQ_CMD: begin
              if (data_byte_i != CMD_CONNECT) begin
                push_o = 1'b1; cmd_o.job = JOB_FAIL; phase_d = PH_FAILED;
              end else phase_d = PH_REQ_RSV;
            end
            PH_REQ_RSV: begin
              if (data_byte_i != BYTE_ZERO) begin
                push_o = 1'b1; cmd_o.job = JOB_FAIL; phase_d = PH_FAILED;
              end else phase_d = PH_REQ_ATYP;
            end
            PH_REQ_ATYP: begin
              cnt_d  = '0;
              port_d = '0;
              if (data_byte_i == ATYP_IPV4) begin
                ak_d = AK_IPV4; phase_d = PH_ADDR;
              end else if (data_byte_i == ATYP_DOMAIN) begin
                ak_d = AK_DOMAIN; phase_d = PH_NAME_LEN;
              end else if (data_byte_i == ATYP_IPV6) begin
                ak_d = AK_IPV6; phase_d = PH_ADDR;
              end else begin
                push_o = 1'b1; cmd_o.job = JOB_FAIL; phase_d = PH_FAILED;
              end
            end
            PH_NAME_LEN: begin
              nlen_d  = data_byte_i;
              cnt_d   = '0;
              phase_d = PH_ADDR;
            end
            PH_ADDR: begin
              if (cnt_q < alen) begin
                wr_o.we   = (ak_q != AK_DOMAIN);
                wr_o.addr = cnt_q[3:0];
                wr_o.data = data_byte_i;
              end else begin
                port_d = {port_q[7:0], data_byte_i};
              end
              cnt_d = cnt_inc;
              push_o = 1'b1;
              cmd_o.single    = 1'b1;
              cmd_o.kind      = KIND_DEST;
              cmd_o.data      = data_byte_i;
              cmd_o.dest_type = ak_q;
              cmd_o.last      = (cnt_inc >= total);
              if (cnt_inc >= total) begin
                phase_d = PH_WAIT; cnt_d = '0;
              end
            end
            PH_RELAY: begin
              push_o = 1'b1;
              cmd_o.single    = 1'b1;
              cmd_o.kind      = KIND_RELAY;
              cmd_o.data      = data_byte_i;
              cmd_o.dest_type = ak_q;
            end
            default: ;
          endcase
        end
        OP_RESOLVED: begin
          if (phase_q == PH_WAIT) begin
            wr_o.we   = 1'b1;
            wr_o.addr = cnt_q[3:0];
            wr_o.data = data_byte_i;
            cnt_d     = cnt_inc;
          end
        end
        OP_OUTCOME: begin
          if (phase_q == PH_WAIT) begin
            push_o = 1'b1;
            if (!connect_ok_i) begin
              cmd_o.job = JOB_FAIL; phase_d = PH_FAILED;
            end else begin
              cmd_o.job = JOB_OK;
              cmd_o.v6  = (ak_q == AK_DOMAIN) ? resolved_is_ipv6_i : (ak_q == AK_IPV6);
              phase_d   = PH_RELAY;
              okpend_d  = 1'b1;
            end
          end
        end
        default: begin
          phase_d  = PH_GREET_VER;
          cnt_d    = '0;
          mtot_d   = '0;
          noauth_d = 1'b0;
          ak_d     = AK_IPV4;
          nlen_d   = '0;
          port_d   = '0;
        end
      endcase
    end
    cmd_o.dest_type = ak_q;
    cmd_o.port      = port_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_GREET_VER;
      cnt_q    <= '0;
      mtot_q   <= '0;
      noauth_q <= 1'b0;
      ak_q     <= AK_IPV4;
      nlen_q   <= '0;
      port_q   <= '0;
      okpend_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      mtot_q   <= mtot_d;
      noauth_q <= noauth_d;
      ak_q     <= ak_d;
      nlen_q   <= nlen_d;
      port_q   <= port_d;
      okpend_q <= okpend_d;
    end
  end

endmodule

/* hdl/s5hp_queue.sv */
module s5hp_queue
  import s5hp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  output logic valid_o,
  output cmd_t cmd_o,
  input  logic pop_i
);

  localparam int Depth = 4;

  cmd_t       mem_q [Depth];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 3'(Depth));
  assign valid_o = (cnt_q != 3'd0);
  assign cmd_o   = mem_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= wp_q + 2'd1;
      if (do_pop) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + 3'(do_push) - 3'(do_pop);
    end
  end

endmodule

/* hdl/s5hp_back.sv */
module s5hp_back
  import s5hp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  cmd_t       cmd_i,
  output logic       pop_o,
  input  wr_t        wr_i,
  output logic       m_valid_o,
  input  logic       m_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] byte_o,
  output logic [1:0] dest_type_o,
  output logic       failed_o,
  output logic       last_o
);

  logic [7:0]  store_q [16];
  logic [4:0]  idx_q, idx_d;
  logic [4:0]  len;
  logic        ovalid_q;
  logic [1:0]  okind_q;
  logic [7:0]  obyte_q, obyte_d;
  logic [1:0]  otype_q;
  logic        ofail_q, ofail_d, olast_q, olast_d;
  logic        take;
  logic [4:0]  alen;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) store_q[wr_i.addr] <= wr_i.data;
  end

  assign take  = !ovalid_q || m_ready_i;
  assign alen  = cmd_i.v6 ? 5'd16 : 5'd4;
  assign len   = cmd_i.single ? 5'd1 :
                 (cmd_i.job == JOB_METHOD) ? 5'd2 :
                 (cmd_i.job == JOB_FAIL) ? 5'd10 : alen + 5'd6;
  assign pop_o = valid_i && take && (idx_q + 5'd1 == len);
  assign idx_d = !(valid_i && take) ? idx_q : (pop_o ? 5'd0 : idx_q + 5'd1);

  always_comb begin
    obyte_d = BYTE_ZERO;
    ofail_d = 1'b0;
    olast_d = (idx_q + 5'd1 == len);
    if (cmd_i.single) begin
      obyte_d = cmd_i.data;
      olast_d = cmd_i.last;
    end else begin
      case (cmd_i.job)
        JOB_METHOD: begin
          ofail_d = cmd_i.bad;
          obyte_d = (idx_q == 5'd0) ? SOCKS_VER : (cmd_i.bad ? NO_METHOD : BYTE_ZERO);
        end
        JOB_FAIL: begin
          ofail_d = 1'b1;
          case (idx_q)
            5'd0, 5'd1: obyte_d = SOCKS_VER;
            5'd3:       obyte_d = REP_FAIL;
            default:    obyte_d = BYTE_ZERO;
          endcase
        end
        JOB_OK: begin
          if (idx_q == 5'd0) obyte_d = SOCKS_VER;
          else if (idx_q == 5'd3) obyte_d = cmd_i.v6 ? ATYP_IPV6 : ATYP_IPV4;
          else if (idx_q < 5'd3) obyte_d = BYTE_ZERO;
          else if (idx_q < alen + 5'd4) obyte_d = store_q[4'(idx_q - 5'd4)];
          else if (idx_q == alen + 5'd4) obyte_d = cmd_i.port[15:8];
          else obyte_d = cmd_i.port[7:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (take) ovalid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && valid_i) begin
      okind_q <= cmd_i.single ? cmd_i.kind : KIND_REPLY;
      obyte_q <= obyte_d;
      otype_q <= cmd_i.dest_type;
      ofail_q <= ofail_d;
      olast_q <= olast_d;
    end
  end

  assign m_valid_o   = ovalid_q;
  assign kind_o      = okind_q;
  assign byte_o      = obyte_q;
  assign dest_type_o = otype_q;
  assign failed_o    = ofail_q;
  assign last_o      = olast_q;

endmodule

/* hdl/socks5_handshake_parser.sv */
// SOCKS5 client-side handshake parser. Takes one input transfer per cycle and
// classifies it in the front end; client bytes that only advance the parse
// produce nothing, destination and relay bytes produce one output transfer,
// and replies are bursts of 2, 10 or 22 output transfers generated by the
// back end, one byte per cycle unless the output stalls, reading the 16-entry
// address store. A 4-entry command queue decouples the two, so input stalls
// when that queue is full, and also from an accepted successful connect
// outcome until the back end has taken the last byte of its success reply,
// so that the stored address it reads cannot be overwritten first. Stored
// address bytes are valid only once written in the session.
module socks5_handshake_parser
  import s5hp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // data_byte[7:0], connect_ok[8], resolved_is_ipv6[9]
  input  logic [1:0]  s_axis_tuser,  // operation[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // out_byte[7:0], dest_type[9:8], session_failed[10]
  output logic [1:0]  m_axis_tuser,  // kind[1:0]
  output logic        m_axis_tlast
);

  cmd_t fq_cmd, qb_cmd;
  wr_t  wr;
  logic push, full, qvalid, pop;
  logic ok_done;
  logic [7:0] ob;
  logic [1:0] dt;
  logic       fl;

  assign ok_done = pop && !qb_cmd.single && (qb_cmd.job == JOB_OK);

  s5hp_front u_front (
    .clk_i, .rst_ni,
    .valid_i(s_axis_tvalid), .ready_o(s_axis_tready),
    .operation_i(s_axis_tuser), .data_byte_i(s_axis_tdata[7:0]),
    .connect_ok_i(s_axis_tdata[8]), .resolved_is_ipv6_i(s_axis_tdata[9]),
    .push_o(push), .cmd_o(fq_cmd), .full_i(full), .ok_done_i(ok_done), .wr_o(wr)
  );

  s5hp_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .cmd_i(fq_cmd), .full_o(full),
    .valid_o(qvalid), .cmd_o(qb_cmd), .pop_i(pop)
  );

  s5hp_back u_back (
    .clk_i, .rst_ni,
    .valid_i(qvalid), .cmd_i(qb_cmd), .pop_o(pop), .wr_i(wr),
    .m_valid_o(m_axis_tvalid), .m_ready_i(m_axis_tready),
    .kind_o(m_axis_tuser), .byte_o(ob), .dest_type_o(dt),
    .failed_o(fl), .last_o(m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, fl, dt, ob};

endmodule

/* bench/socks5_checker.sv */
`timescale 1ns / 1ps
module socks5_checker
  import s5hp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  output int          fail_count_o,
  output int          pending_o
);

  typedef enum logic [3:0] {
    P_GREET_VER, P_GREET_NUM, P_METHODS, P_REQ_VER, P_REQ_CMD, P_REQ_RSV,
    P_REQ_ATYP, P_NAME_LEN, P_ADDR, P_WAIT, P_RELAY, P_FAILED
  } phase_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [1:0] dtype;
    logic       failed;
    logic       last;
  } reply_byte_t;

  reply_byte_t expected_q[$];
  phase_e      phase;
  logic [8:0]  cnt;
  logic [7:0]  method_total;
  logic        no_auth;
  logic [1:0]  akind;
  logic [7:0]  name_len;
  logic [7:0]  addr_mem[16];
  logic [15:0] port;
  int          fails;

  assign fail_count_o = fails;
  assign pending_o = expected_q.size();

  task automatic push(logic [1:0] k, logic [7:0] b, logic f, logic l);
    expected_q.push_back('{k, b, akind, f, l});
  endtask

  task automatic session_clear();
    phase = P_GREET_VER; cnt = 0; method_total = 0; no_auth = 0;
    akind = AK_IPV4; name_len = 0; port = 0;
    for (int i = 0; i < 16; i++) addr_mem[i] = 0;
  endtask

  task automatic fail_burst();
    logic [7:0] msg[10];
    msg = '{SOCKS_VER, 8'h05, BYTE_ZERO, ATYP_IPV4, 0, 0, 0, 0, 0, 0};
    for (int i = 0; i < 10; i++) push(KIND_REPLY, msg[i], 1'b1, i == 9);
    phase = P_FAILED;
  endtask

  task automatic method_burst();
    push(KIND_REPLY, SOCKS_VER, !no_auth, 1'b0);
    push(KIND_REPLY, no_auth ? BYTE_ZERO : NO_METHOD, !no_auth, 1'b1);
    phase = no_auth ? P_REQ_VER : P_FAILED;
  endtask

  task automatic ok_burst(logic v6);
    push(KIND_REPLY, SOCKS_VER, 0, 0);
    push(KIND_REPLY, BYTE_ZERO, 0, 0);
    push(KIND_REPLY, BYTE_ZERO, 0, 0);
    push(KIND_REPLY, v6 ? ATYP_IPV6 : ATYP_IPV4, 0, 0);
    for (int i = 0; i < (v6 ? 16 : 4); i++) push(KIND_REPLY, addr_mem[i], 0, 0);
    push(KIND_REPLY, port[15:8], 0, 0);
    push(KIND_REPLY, port[7:0], 0, 1);
    phase = P_RELAY;
  endtask

  task automatic predict_client(logic [7:0] b);
    int alen;
    case (phase)
      P_GREET_VER: if (b != SOCKS_VER) fail_burst(); else phase = P_GREET_NUM;
      P_GREET_NUM: begin
        method_total = b; cnt = 0; no_auth = 0;
        if (b == 0) method_burst(); else phase = P_METHODS;
      end
      P_METHODS: begin
        if (b == BYTE_ZERO) no_auth = 1;
        cnt = cnt + 9'd1;
        if (cnt >= method_total) method_burst();
      end
      P_REQ_VER: if (b != SOCKS_VER) fail_burst(); else phase = P_REQ_CMD;
      P_REQ_CMD: if (b != CMD_CONNECT) fail_burst(); else phase = P_REQ_RSV;
      P_REQ_RSV: if (b != BYTE_ZERO) fail_burst(); else phase = P_REQ_ATYP;
      P_REQ_ATYP: begin
        cnt = 0; port = 0;
        if (b == ATYP_IPV4) begin akind = AK_IPV4; phase = P_ADDR; end
        else if (b == ATYP_DOMAIN) begin akind = AK_DOMAIN; phase = P_NAME_LEN; end
        else if (b == ATYP_IPV6) begin akind = AK_IPV6; phase = P_ADDR; end
        else fail_burst();
      end
      P_NAME_LEN: begin name_len = b; cnt = 0; phase = P_ADDR; end
      P_ADDR: begin
        alen = akind == AK_IPV4 ? 4 : (akind == AK_IPV6 ? 16 : name_len);
        if (cnt < alen) begin
          if (akind != AK_DOMAIN) addr_mem[cnt[3:0]] = b;
        end else port = {port[7:0], b};
        cnt = cnt + 9'd1;
        if (cnt >= alen + 2) begin
          push(KIND_DEST, b, 0, 1);
          phase = P_WAIT; cnt = 0;
        end else push(KIND_DEST, b, 0, 0);
      end
      P_RELAY: push(KIND_RELAY, b, 0, 0);
      default: ;
    endcase
  endtask

  task automatic report(string what, reply_byte_t got, reply_byte_t exp);
    $display("mismatch %s: got k=%0d b=%02h t=%0d f=%0b l=%0b exp k=%0d b=%02h t=%0d f=%0b l=%0b",
             what, got.kind, got.data, got.dtype, got.failed, got.last,
             exp.kind, exp.data, exp.dtype, exp.failed, exp.last);
    fails++;
  endtask

  initial begin
    fails = 0;
    session_clear();
  end

  always @(posedge clk_i) begin
    reply_byte_t got, exp;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[9:8], m_axis_tdata[10],
              m_axis_tlast};
      if (expected_q.size() == 0) report("unexpected", got, '0);
      else begin
        exp = expected_q.pop_front();
        if (got != exp) report("field", got, exp);
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      case (s_axis_tuser)
        OP_CLIENT: predict_client(s_axis_tdata[7:0]);
        OP_RESOLVED: if (phase == P_WAIT) begin
          addr_mem[cnt[3:0]] = s_axis_tdata[7:0];
          cnt = cnt + 9'd1;
        end
        OP_OUTCOME: if (phase == P_WAIT) begin
          if (!s_axis_tdata[8]) fail_burst();
          else if (akind == AK_DOMAIN) ok_burst(s_axis_tdata[9]);
          else ok_burst(akind == AK_IPV6);
        end
        default: session_clear();
      endcase
    end
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import s5hp_pkg::*;

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid, m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  int          fail_count, pending;
  int          sent;
  bit          hold_sink;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] b;
    logic       ok;
    logic       v6;
  } xfer_t;

  xfer_t stim_q[$];

  socks5_handshake_parser DUT (.*);

  socks5_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("FAIL socks5_handshake_parser");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic add(logic [1:0] op, logic [7:0] b, logic ok = 0, logic v6 = 0);
    stim_q.push_back('{op, b, ok, v6});
  endtask

  task automatic add_greeting(bit good);
    int n;
    n = $urandom_range(1, 4);
    add(OP_CLIENT, SOCKS_VER);
    add(OP_CLIENT, 8'(n));
    for (int i = 0; i < n; i++)
      add(OP_CLIENT, (good && i == n - 1) ? BYTE_ZERO : 8'($urandom_range(1, 255)));
  endtask

  task automatic add_session();
    int sel, alen;
    logic [7:0] atyp;
    add(OP_RESTART, 8'($urandom));
    add_greeting($urandom_range(0, 9) != 0);
    add(OP_CLIENT, $urandom_range(0, 19) ? SOCKS_VER : 8'($urandom));
    add(OP_CLIENT, $urandom_range(0, 19) ? CMD_CONNECT : 8'($urandom));
    add(OP_CLIENT, $urandom_range(0, 19) ? BYTE_ZERO : 8'($urandom));
    sel = $urandom_range(0, 20);
    atyp = sel < 7 ? ATYP_IPV4 : sel < 14 ? ATYP_DOMAIN : sel < 20 ? ATYP_IPV6 : 8'($urandom);
    add(OP_CLIENT, atyp);
    alen = atyp == ATYP_IPV6 ? 16 : 4;
    if (atyp == ATYP_DOMAIN) begin
      alen = $urandom_range(0, 5);
      add(OP_CLIENT, 8'(alen));
    end
    for (int i = 0; i < alen + 2; i++) add(OP_CLIENT, 8'($urandom));
    if (atyp == ATYP_DOMAIN) begin
      for (int i = 0; i < 16; i++) add(OP_RESOLVED, 8'($urandom));
      add(OP_CLIENT, 8'($urandom));
    end
    add(OP_OUTCOME, 8'($urandom), $urandom_range(0, 5) != 0, 1'($urandom));
    for (int i = $urandom_range(0, 4); i > 0; i--)
      add(2'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  initial begin
    s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tuser = 0;
    rst_ni = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;

    add(OP_CLIENT, 8'h04);
    add(OP_RESTART, 0);
    add(OP_CLIENT, SOCKS_VER); add(OP_CLIENT, 0);
    add(OP_RESTART, 0);
    add(OP_CLIENT, SOCKS_VER); add(OP_CLIENT, 2); add(OP_CLIENT, 8'hFF); add(OP_CLIENT, 0);
    add(OP_OUTCOME, 0, 1, 1);
    add(OP_CLIENT, SOCKS_VER); add(OP_CLIENT, 8'h02);
    add(OP_RESTART, 0);
    add(OP_CLIENT, SOCKS_VER); add(OP_CLIENT, 1); add(OP_CLIENT, 0);
    add(OP_CLIENT, SOCKS_VER); add(OP_CLIENT, CMD_CONNECT); add(OP_CLIENT, BYTE_ZERO);
    add(OP_CLIENT, ATYP_DOMAIN); add(OP_CLIENT, 0); add(OP_CLIENT, 8'hFF); add(OP_CLIENT, 8'h00);
    add(OP_RESOLVED, 8'h0A); add(OP_RESOLVED, 8'h00);
    add(OP_RESOLVED, 8'h00); add(OP_RESOLVED, 8'h01);
    add(OP_OUTCOME, 0, 1, 0);
    add(OP_CLIENT, 8'hAA);

    while (stim_q.size() < 160) add_session();

    while (stim_q.size() > 0) begin
      xfer_t x;
      int g;
      x = stim_q.pop_front();
      g = gap_len();
      if (g > 0) begin
        s_axis_tvalid <= 0;
        repeat (g) @(posedge clk_i);
      end
      s_axis_tvalid <= 1;
      s_axis_tuser  <= x.op;
      s_axis_tdata  <= {6'b0, x.v6, x.ok, x.b};
      do @(posedge clk_i); while (!s_axis_tready);
      sent++;
    end
    s_axis_tvalid <= 0;

    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) $display("PASS socks5_handshake_parser");
    else $display("FAIL socks5_handshake_parser");
    $finish;
  end

  initial begin
    sent = 0;
    hold_sink = 0;
    wait (sent >= 40);
    hold_sink = 1;
    repeat (300) @(posedge clk_i);
    hold_sink = 0;
  end

  initial begin
    m_axis_tready = 0;
    @(posedge rst_ni);
    forever begin
      int g;
      g = gap_len();
      if (hold_sink || g > 0) begin
        m_axis_tready <= 0;
        if (hold_sink) @(posedge clk_i);
        else repeat (g) @(posedge clk_i);
      end
      m_axis_tready <= !hold_sink;
      @(posedge clk_i);
    end
  end

endmodule
